/* design/sem_pkg.sv */
// Shared constants and types for the Sobel edge magnitude block.
package sem_pkg;

  // Default maximum image dimensions
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Pixel and register widths
  localparam int PIX_W      = 8;
  localparam int CFG_W_W    = 12;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_TDATA_W = 3 * PIX_W;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register reset values
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Square root unit: 16-bit radicand, 8-bit root, two radicand bits per step
  localparam int RAD_W    = 16;
  localparam int ROOT_W   = 8;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS);

  // Sum of squares of two gradients of at most 1020 in magnitude
  localparam int GRAD_W = 11;
  localparam int MAG2_W = 21;

  localparam logic [ROOT_W-1:0] SAT_VALUE = 8'd255;

  typedef struct packed {
    logic              start;
    logic [RAD_W-1:0]  radicand;
  } sq_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sq_rsp_t;

endpackage

/* design/sem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/sem_fifo.sv */
// Small register queue between the front and the back of the edge pipeline.
module sem_fifo #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/sem_isqrt.sv */
// Digit-serial integer square root, one root bit per cycle.
module sem_isqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  sem_pkg::sq_req_t  req,
  output sem_pkg::sq_rsp_t  rsp
);

  import sem_pkg::*;

  localparam int REM_W = ROOT_W + 1;
  localparam int SH_W  = REM_W + 2;

  logic                busy_r;
  logic                done_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [SH_W-1:0]     rem_sh;
  logic [SH_W-1:0]     trial;
  logic [SH_W-1:0]     diff;
  logic                fits;

  // Bring down the next two radicand bits and try root*4+1
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = SH_W'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == SQ_CNT_W'(SQ_STEPS - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SQ_CNT_W'(1);
        if (cnt_r == SQ_CNT_W'(SQ_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

/* design/sem_fe.sv */
// Front end: pixel intake, gray conversion, raster position and frame registers.
module sem_fe #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int ROW_W     = $clog2(MAX_HEIGHT),
  localparam int ENT_W     = sem_pkg::PIX_W + COL_W + ROW_W + 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sem_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            push,
  output logic [ENT_W-1:0]                push_data,
  input  logic                            full
);

  import sem_pkg::*;

  // Last valid index of a dimension after clamping it to [3, hi]
  function automatic logic [31:0] dim_last(input logic [31:0] v, input logic [31:0] hi);
    logic [31:0] res;
    if (v < 32'd3) begin
      res = 32'd2;
    end else if (v > hi) begin
      res = hi - 32'd1;
    end else begin
      res = v - 32'd1;
    end
    return res;
  endfunction

  localparam logic [COL_W-1:0] COL_MAX_RST =
    COL_W'(dim_last(32'(RESET_WIDTH), 32'(MAX_WIDTH)));
  localparam logic [ROW_W-1:0] ROW_MAX_RST =
    ROW_W'(dim_last(32'(RESET_HEIGHT), 32'(MAX_HEIGHT)));

  localparam int SUM_W  = PIX_W + 2;
  localparam int PROD_W = SUM_W + 10;
  localparam logic [9:0] DIV3_MUL = 10'd683;
  localparam int DIV3_SHIFT = 11;

  logic [COL_W-1:0] col_max_r, col_max_nxt;
  logic [ROW_W-1:0] row_max_r, row_max_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             accept;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic [SUM_W-1:0] sum;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0] gray;
  logic             emit;
  logic             last;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  // Restart at the origin if the position is outside the frame
  assign c = ((col_r > col_max_r) || (row_r > row_max_r)) ? '0 : col_r;
  assign r = ((col_r > col_max_r) || (row_r > row_max_r)) ? '0 : row_r;

  // floor(sum/3) as (sum*683)>>11, exact for sums up to 765
  assign sum  = SUM_W'(in_tdata[PIX_W-1:0]) + SUM_W'(in_tdata[2*PIX_W-1:PIX_W])
              + SUM_W'(in_tdata[3*PIX_W-1:2*PIX_W]);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
  assign gray = prod[DIV3_SHIFT +: PIX_W];

  assign emit = (c >= COL_W'(2)) && (r >= ROW_W'(2));
  assign last = (c == col_max_r) && (r == row_max_r);

  assign push      = accept;
  assign push_data = {last, emit, r, c, gray};

  always_comb begin
    col_max_nxt = col_max_r;
    row_max_nxt = row_max_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          col_max_nxt = COL_W'(dim_last(32'(cfg_wdata[CFG_W_W-1:0]), 32'(MAX_WIDTH)));
        end
        REG_IMAGE_HEIGHT: begin
          row_max_nxt = ROW_W'(dim_last(32'(cfg_wdata[CFG_H_W-1:0]), 32'(MAX_HEIGHT)));
        end
        default: begin
          col_max_nxt = col_max_r;
        end
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (c == col_max_r) begin
        col_nxt = '0;
        row_nxt = (r == row_max_r) ? '0 : r + ROW_W'(1);
      end else begin
        col_nxt = c + COL_W'(1);
        row_nxt = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_max_r <= COL_MAX_RST;
      row_max_r <= ROW_MAX_RST;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      col_max_r <= col_max_nxt;
      row_max_r <= row_max_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

/* design/sem_be.sv */
// Back end: line stores, 3x3 window, Sobel gradients, root and result register.
module sem_be #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int ROW_W     = $clog2(MAX_HEIGHT),
  localparam int ENT_W     = sem_pkg::PIX_W + COL_W + ROW_W + 2,
  localparam int DATA_BITS = sem_pkg::PIX_W + COL_W + ROW_W,
  localparam int OUT_TDATA_W = ((DATA_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  output logic                   pop,
  input  logic [ENT_W-1:0]       pop_data,
  input  logic                   empty,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  import sem_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIN  = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_ROOT = 6'b001000,
    ST_WAIT = 6'b010000,
    ST_DONE = 6'b100000
  } be_state_t;

  function automatic logic signed [GRAD_W-1:0] px(input logic [PIX_W-1:0] p);
    return $signed(GRAD_W'(p));
  endfunction

  be_state_t state_r, state_nxt;

  logic [PIX_W-1:0]  win_r [3][3];
  logic [PIX_W-1:0]  cur_gray_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic              cur_emit_r;
  logic              cur_last_r;
  logic [MAG2_W-1:0] mag2_r;
  logic [ROOT_W-1:0] root_r;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_edge_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;

  logic [PIX_W-1:0]  up_rdata;
  logic [PIX_W-1:0]  mid_rdata;
  logic              ram_we;
  logic              load;

  logic signed [GRAD_W-1:0]   gx, gy;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [MAG2_W-1:0]          mag2;
  logic                       sat;

  sq_req_t sq_req;
  sq_rsp_t sq_rsp;

  assign pop    = (state_r == ST_IDLE) && !empty;
  assign ram_we = (state_r == ST_WIN);
  assign load   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // Upper store takes the old middle entry, middle store takes the new gray
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col_r),
    .wdata (mid_rdata),
    .re    (pop),
    .raddr (pop_data[PIX_W +: COL_W]),
    .rdata (up_rdata)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col_r),
    .wdata (cur_gray_r),
    .re    (pop),
    .raddr (pop_data[PIX_W +: COL_W]),
    .rdata (mid_rdata)
  );

  // Gradients: right minus left column, bottom minus top row, weights 1,2,1
  assign gx = (px(win_r[0][2]) - px(win_r[0][0]))
            + ((px(win_r[1][2]) - px(win_r[1][0])) <<< 1)
            + (px(win_r[2][2]) - px(win_r[2][0]));
  assign gy = (px(win_r[2][0]) - px(win_r[0][0]))
            + ((px(win_r[2][1]) - px(win_r[0][1])) <<< 1)
            + (px(win_r[2][2]) - px(win_r[0][2]));
  assign gx_sq = gx * gx;
  assign gy_sq = gy * gy;
  assign mag2  = gx_sq[MAG2_W-1:0] + gy_sq[MAG2_W-1:0];
  assign sat   = (mag2_r[MAG2_W-1:RAD_W] != '0);

  assign sq_req.start    = (state_r == ST_ROOT) && !sat;
  assign sq_req.radicand = mag2_r[RAD_W-1:0];

  sem_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!empty) begin
        state_nxt = ST_WIN;
      end
      ST_WIN: begin
        state_nxt = cur_emit_r ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        state_nxt = sat ? ST_DONE : ST_WAIT;
      end
      ST_WAIT: if (sq_rsp.done) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (load) begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (state_r == ST_WIN) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up_rdata;
      win_r[1][2] <= mid_rdata;
      win_r[2][2] <= cur_gray_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_gray_r <= pop_data[PIX_W-1:0];
      cur_col_r  <= pop_data[PIX_W +: COL_W];
      cur_row_r  <= pop_data[PIX_W + COL_W +: ROW_W];
      cur_emit_r <= pop_data[ENT_W-2];
      cur_last_r <= pop_data[ENT_W-1];
    end
    if (state_r == ST_GRAD) begin
      mag2_r <= mag2;
    end
    if ((state_r == ST_ROOT) && sat) begin
      root_r <= SAT_VALUE;
    end else if ((state_r == ST_WAIT) && sq_rsp.done) begin
      root_r <= sq_rsp.root;
    end
    if (load) begin
      out_edge_r <= root_r;
      out_col_r  <= cur_col_r - COL_W'(1);
      out_row_r  <= cur_row_r - ROW_W'(1);
      out_last_r <= cur_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_row_r, out_col_r, out_edge_r});
  assign out_tlast  = out_last_r;

endmodule

/* design/sobel_edge_magnitude.sv */
// Top level of the Sobel edge magnitude block over an RGB raster stream.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------------
//  in_     | slave     | in_tvalid/tready   | red, green, blue (8 bit each)
//  out_    | master    | out_tvalid/tready  | edge_value, center_col, center_row; tlast
//  cfg_    | write     | cfg_we             | image_width (idx 0), image_height (idx 1)
//
//  Steps: a pixel that completes no result passes the back end as a pop with line-store
//  read, then a window update; one that completes a result adds the gradient, root launch
//  and hand-off steps plus the 8-step one-bit-per-cycle square root and its done, which
//  are skipped when the magnitude saturates.
//  The front takes a pixel every cycle while the 4-entry queue has room.
//  Reset (rst_n low, synchronous) empties the queue, clears the output valid and
//  loads 640 x 480; the line stores are not cleared.
//  A stalled output holds its transaction while the back end finishes the next item.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH    = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = sem_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W       = $clog2(MAX_WIDTH),
  localparam int ROW_W       = $clog2(MAX_HEIGHT),
  localparam int DATA_BITS   = sem_pkg::PIX_W + COL_W + ROW_W,
  localparam int OUT_TDATA_W = ((DATA_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // register write port
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // pixel input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sem_pkg::IN_TDATA_W-1:0]  in_tdata,   // red, green, blue
  // edge output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_TDATA_W-1:0]          out_tdata,  // edge_value, center_col, center_row, 0 pad
  output logic                            out_tlast   // final interior pixel of the frame
);

  import sem_pkg::*;

  localparam int ENT_W = PIX_W + COL_W + ROW_W + 2;

  logic             q_push;
  logic [ENT_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [ENT_W-1:0] q_pop_data;
  logic             q_empty;

  // Front: convert to gray, tag with position, border and end-of-frame flags
  sem_fe #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_fe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  // Decouple intake from the multi-cycle back end
  sem_fifo #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  // Back: line stores, window, gradient magnitude, output register
  sem_be #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_be (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop        (q_pop),
    .pop_data   (q_pop_data),
    .empty      (q_empty),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* design/sem_checker.sv */
// Port-level checks for the Sobel edge magnitude block, bound to the top level.
module sem_checker #(
  parameter int MAX_WIDTH    = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = sem_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W       = $clog2(MAX_WIDTH),
  localparam int ROW_W       = $clog2(MAX_HEIGHT),
  localparam int DATA_BITS   = sem_pkg::PIX_W + COL_W + ROW_W,
  localparam int OUT_TDATA_W = ((DATA_BITS + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  import sem_pkg::*;

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output changed");

  // Reported centers never lie on the first row or the first column
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[PIX_W +: COL_W] != '0) && (out_tdata[PIX_W + COL_W +: ROW_W] != '0))
    else $error("border center reported");

endmodule

bind sobel_edge_magnitude sem_checker #(
  .MAX_WIDTH  (MAX_WIDTH),
  .MAX_HEIGHT (MAX_HEIGHT)
) u_sem_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/tb_sobel_edge_magnitude.sv */
// Self-checking testbench for the Sobel edge magnitude block.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  // Output payload layout: edge_value, center_col, center_row, zero pad
  localparam int COL_W        = $clog2(MAX_WIDTH_DEF);
  localparam int ROW_W        = $clog2(MAX_HEIGHT_DEF);
  localparam int OUT_DATA_W   = ((PIX_W + COL_W + ROW_W + 7) / 8) * 8;
  localparam int COL_LSB      = PIX_W;
  localparam int ROW_LSB      = PIX_W + COL_W;
  // Cycles to let the back end empty its queue of result-less pixels
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int MAX_GAP       = 16;
  localparam int MAX_REPORTS   = 10;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [PIX_W-1:0] edge_value;
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic             last;
  } edge_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // red, green, blue
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;        // edge_value, center_col, center_row, pad
  logic                   out_tlast;        // final interior pixel of the frame

  // Gradient predictor state
  logic [CFG_W_W-1:0]     model_width;
  logic [CFG_H_W-1:0]     model_height;
  logic [PIX_W-1:0]       line_upper  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]       line_middle [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]       win [3][3];       // [row][col], col 2 newest
  int                     col_pos;
  int                     row_pos;

  edge_result_t           expected_edges[$];
  int                     edge_mismatches = 0;
  int                     cycle_count     = 0;
  int                     send_idle_pct   = 0;
  int                     recv_stall_pct  = 0;

  sobel_edge_magnitude u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sobel_edge_magnitude: FAILED **");
      $finish;
    end
  end

  // Receiver: drop tready at random per the current idling mode
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result transaction against the oldest prediction
  always @(posedge clk) begin : edge_checker
    edge_result_t got;
    edge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.edge_value = out_tdata[PIX_W-1:0];
      got.center_col = out_tdata[COL_LSB +: COL_W];
      got.center_row = out_tdata[ROW_LSB +: ROW_W];
      got.last       = out_tlast;
      if (expected_edges.size() == 0) begin
        edge_mismatches++;
        if (edge_mismatches <= MAX_REPORTS)
          $display("unexpected result: value=%0d col=%0d row=%0d last=%0b",
                   got.edge_value, got.center_col, got.center_row, got.last);
      end else begin
        want = expected_edges.pop_front();
        if (got.edge_value !== want.edge_value || got.center_col !== want.center_col ||
            got.center_row !== want.center_row || got.last !== want.last) begin
          edge_mismatches++;
          if (edge_mismatches <= MAX_REPORTS) begin
            $display("result mismatch: expected value=%0d col=%0d row=%0d last=%0b",
                     want.edge_value, want.center_col, want.center_row, want.last);
            $display("                 got      value=%0d col=%0d row=%0d last=%0b",
                     got.edge_value, got.center_col, got.center_row, got.last);
          end
        end
      end
    end
  end

  function automatic int dim_limit(input int v, input int hi);
    if (v < 3)
      return 3;
    if (v > hi)
      return hi;
    return v;
  endfunction

  // Advance the predictor by one pixel; queue the result it completes, if any
  function automatic void predict_edge(input logic [IN_TDATA_W-1:0] rgb);
    int w, h, c, r, gx, gy, wt, mag2, mag;
    logic [9:0] sum;
    logic [PIX_W-1:0] gray, up, mid;
    edge_result_t want;
    w = dim_limit(int'(model_width), MAX_WIDTH_DEF);
    h = dim_limit(int'(model_height), MAX_HEIGHT_DEF);
    c = col_pos;
    r = row_pos;
    sum = 10'(rgb[7:0]) + 10'(rgb[15:8]) + 10'(rgb[23:16]);
    gray = 8'(sum / 3);
    if (c >= w || r >= h) begin
      c = 0;
      r = 0;
    end
    up = line_upper[c];
    mid = line_middle[c];
    line_upper[c] = mid;
    line_middle[c] = gray;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = gray;
    if (c >= 2 && r >= 2) begin
      gx = 0;
      gy = 0;
      for (int i = 0; i < 3; i++) begin
        wt = (i == 1) ? 2 : 1;
        gx += wt * (int'(win[i][2]) - int'(win[i][0]));
        gy += wt * (int'(win[2][i]) - int'(win[0][i]));
      end
      mag2 = gx * gx + gy * gy;
      if (mag2 >= 65536) begin
        mag = 255;
      end else begin
        // Build the floor root one bit at a time from the top
        mag = 0;
        for (int b = 7; b >= 0; b--)
          if ((mag | (1 << b)) * (mag | (1 << b)) <= mag2)
            mag = mag | (1 << b);
      end
      want.edge_value = 8'(mag);
      want.center_col = COL_W'(c - 1);
      want.center_row = ROW_W'(r - 1);
      want.last       = (c == w - 1 && r == h - 1);
      expected_edges.push_back(want);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h)
        r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_rgb(input int style);
    logic [PIX_W-1:0] lvl;
    case (style)
      0: return IN_TDATA_W'($urandom());
      1: return $urandom_range(1) ? {IN_TDATA_W{1'b1}} : '0;
      2: begin
        lvl = 8'($urandom_range(255));
        return {lvl, lvl, lvl};
      end
      default: begin
        // Smooth area: small gradients
        lvl = 8'(100 + $urandom_range(15));
        return {lvl, lvl, lvl};
      end
    endcase
  endfunction

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 78; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 78; end
      default:       begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // Offer one pixel, hold it until accepted, then predict
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] rgb);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rgb;
    do @(posedge clk); while (!in_tready);
    predict_edge(rgb);
  endtask

  task automatic send_random_pixels(input int count, input int style);
    repeat (count) send_pixel(random_rgb(style));
  endtask

  // Stop offering pixels until every predicted result has been seen
  task automatic hold_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_edges.size() != 0) @(posedge clk);
  endtask

  // Drain results, then give the back end time to finish result-less pixels
  task automatic settle_block();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; every write also restarts the frame
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH)
      model_width = value[CFG_W_W-1:0];
    else
      model_height = value[CFG_H_W-1:0];
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // Reset geometry 640 x 480: two full rows and 8 pixels of the third
  task automatic test_reset_defaults();
    set_idling(IDLE_RECEIVER);
    send_random_pixels(2 * RESET_WIDTH + 8, 0);
    settle_block();
  endtask

  // Three back-to-back 3x3 frames: saturated edge, flat area, small gradient
  task automatic test_directed();
    logic [IN_TDATA_W-1:0] px [27];
    set_idling(IDLE_BOTH);
    set_frame(3, 3);
    // values as {blue, green, red}
    px = '{24'h000000, 24'h000000, 24'hFFFFFF,
           24'h000000, 24'h000000, 24'hFFFFFF,
           24'h000000, 24'h000000, 24'hFFFFFF,
           24'hFFFFFE, 24'hFFFFFE, 24'hFFFFFE,
           24'hFFFFFE, 24'hFFFFFE, 24'hFFFFFE,
           24'hFFFFFE, 24'hFFFFFE, 24'hFFFFFE,
           24'h000101, 24'h020202, 24'h0000FF,
           24'h030000, 24'h000009, 24'h008000,
           24'hFF0000, 24'h060606, 24'h010001};
    foreach (px[i])
      send_pixel(px[i]);
    settle_block();
  endtask

  // Out-of-range sizes act as the nearest limit; width ignores data bit 12
  task automatic test_dimension_clamps();
    logic [CFG_DATA_W-1:0] ws [4];
    logic [CFG_DATA_W-1:0] hs [4];
    set_idling(IDLE_SENDER);
    ws = '{13'd0, 13'd1, 13'd2, 13'h1005};
    hs = '{13'd2, 13'd1, 13'd0, 13'd3};
    foreach (ws[i]) begin
      set_frame(ws[i], hs[i]);
      send_random_pixels(dim_limit(int'(ws[i][CFG_W_W-1:0]), MAX_WIDTH_DEF) *
                         dim_limit(int'(hs[i]), MAX_HEIGHT_DEF) + 2, i % 4);
      settle_block();
    end
  endtask

  // A write in mid-frame restarts the frame while the stores keep their contents
  task automatic test_restart_on_write();
    set_idling(IDLE_BOTH);
    set_frame(6, 5);
    send_random_pixels(6 * 3 + 2, 0);
    settle_block();
    write_reg(REG_IMAGE_WIDTH, 6);
    send_random_pixels(6 * 5, 2);
    send_random_pixels(8, 0);
    settle_block();
    write_reg(REG_IMAGE_HEIGHT, 4);
    send_random_pixels(6 * 4 + 3, 0);
    settle_block();
  endtask

  // Widest row, exact and clamped from the top of the register range; the start of
  // the first row gives no result
  task automatic test_wide_frame();
    set_idling(IDLE_NONE);
    set_frame(13'd2048, 13'd3);
    send_random_pixels(24, 0);
    settle_block();
    set_frame(13'h0FFF, 13'd3);
    send_random_pixels(24, 0);
    settle_block();
  endtask

  // Tallest frame, exact and clamped, on the narrowest rows; rows run past small heights
  task automatic test_tall_frame();
    set_idling(IDLE_NONE);
    set_frame(13'd3, 13'd4096);
    send_random_pixels(3 * 24, 0);
    settle_block();
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    send_random_pixels(3 * 8 + 3, 2);
    settle_block();
  endtask

  // Random small frames, sometimes cut short or run twice, sometimes out of range
  task automatic test_random_phase(input idle_mode_t mode, input int budget);
    int sent, total, style;
    logic [CFG_DATA_W-1:0] w, h;
    set_idling(mode);
    sent = 0;
    while (sent < budget) begin
      w = 13'($urandom_range(3, 12));
      h = 13'($urandom_range(3, 8));
      if ($urandom_range(7) == 0)
        w = $urandom_range(1) ? 13'($urandom_range(2)) : 13'h1000 | 13'($urandom_range(3, 9));
      if ($urandom_range(7) == 0)
        h = 13'($urandom_range(2));
      if ($urandom_range(3) == 0) begin
        // Rewrite one register only; the other keeps its value
        if ($urandom_range(1))
          write_reg(REG_IMAGE_WIDTH, w);
        else
          write_reg(REG_IMAGE_HEIGHT, h);
      end else begin
        set_frame(w, h);
      end
      total = $urandom_range(1, 2) *
              dim_limit(int'(model_width), MAX_WIDTH_DEF) *
              dim_limit(int'(model_height), MAX_HEIGHT_DEF);
      if ($urandom_range(4) == 0)
        total = $urandom_range(1, total - 1);
      style = $urandom_range(3);
      repeat (total) begin
        if ($urandom_range(59) == 0)
          hold_for_results();
        send_pixel(random_rgb($urandom_range(4) == 0 ? 0 : style));
      end
      sent += total;
      settle_block();
    end
  endtask

  initial begin
    model_width  = CFG_W_W'(RESET_WIDTH);
    model_height = CFG_H_W'(RESET_HEIGHT);
    col_pos = 0;
    row_pos = 0;
    foreach (line_upper[i]) begin
      line_upper[i]  = '0;
      line_middle[i] = '0;
    end
    foreach (win[i, j])
      win[i][j] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_dimension_clamps();
    test_restart_on_write();
    test_wide_frame();
    test_tall_frame();
    test_random_phase(IDLE_NONE, 70);
    test_random_phase(IDLE_SENDER, 70);
    test_random_phase(IDLE_RECEIVER, 70);
    test_random_phase(IDLE_BOTH, 70);

    settle_block();
    if (edge_mismatches == 0 && expected_edges.size() == 0)
      $display("** sobel_edge_magnitude: PASSED **");
    else
      $display("** sobel_edge_magnitude: FAILED **");
    $finish;
  end

endmodule
